// File: design/scancode_line_editor_unit_macros.svh
// Assertion macros used by the checker file of the scancode line editor.
`ifndef SCANCODE_LINE_EDITOR_UNIT_MACROS_SVH
`define SCANCODE_LINE_EDITOR_UNIT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define SLE_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define SLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sle_pkg.sv
// Shared types, constants and key tables of the scancode line editor.
package sle_pkg;

  // Largest line buffer the design is built for
  localparam int MaxLine  = 256;
  // Length counter is 8 bits, so the usable capacity never exceeds 256
  localparam int CapLimit = (MaxLine < 256) ? MaxLine : 256;

  // Special scan codes
  localparam logic [7:0] CodeShiftLeft     = 8'h2A;
  localparam logic [7:0] CodeShiftRight    = 8'h36;
  localparam logic [7:0] CodeShiftLeftRel  = 8'hAA;
  localparam logic [7:0] CodeShiftRightRel = 8'hB6;
  localparam logic [7:0] CodeEnter         = 8'h1C;
  localparam logic [7:0] CodeBackspace     = 8'h0E;

  // Result kinds
  localparam logic [1:0] KindAppend = 2'd0;
  localparam logic [1:0] KindErase  = 2'd1;
  localparam logic [1:0] KindLine   = 2'd2;

  // Configuration register indexes
  localparam logic RegEchoEnable   = 1'b0;
  localparam logic RegLineCapacity = 1'b1;

  // Outcome of one scan code, handed from the decoder to the top level
  typedef struct packed {
    logic       has_result;
    logic [1:0] kind;
    logic [6:0] char_code;
    logic [7:0] position;
    logic       echo;
    logic       shift_next;
    logic [7:0] length_next;
  } sle_edit_t;

  // Plain key table (letters read as upper case)
  function automatic logic [6:0] plain_key(input logic [7:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      8'd1:  ch = 7'h1B;
      8'd2:  ch = 7'h31;
      8'd3:  ch = 7'h32;
      8'd4:  ch = 7'h33;
      8'd5:  ch = 7'h34;
      8'd6:  ch = 7'h35;
      8'd7:  ch = 7'h36;
      8'd8:  ch = 7'h37;
      8'd9:  ch = 7'h38;
      8'd10: ch = 7'h39;
      8'd11: ch = 7'h30;
      8'd12: ch = 7'h2D;
      8'd13: ch = 7'h3D;
      8'd14: ch = 7'h08;
      8'd15: ch = 7'h09;
      8'd16: ch = 7'h51;
      8'd17: ch = 7'h57;
      8'd18: ch = 7'h45;
      8'd19: ch = 7'h52;
      8'd20: ch = 7'h54;
      8'd21: ch = 7'h59;
      8'd22: ch = 7'h55;
      8'd23: ch = 7'h49;
      8'd24: ch = 7'h4F;
      8'd25: ch = 7'h50;
      8'd26: ch = 7'h5B;
      8'd27: ch = 7'h5D;
      8'd28: ch = 7'h0A;
      8'd30: ch = 7'h41;
      8'd31: ch = 7'h53;
      8'd32: ch = 7'h44;
      8'd33: ch = 7'h46;
      8'd34: ch = 7'h47;
      8'd35: ch = 7'h48;
      8'd36: ch = 7'h4A;
      8'd37: ch = 7'h4B;
      8'd38: ch = 7'h4C;
      8'd39: ch = 7'h3B;
      8'd40: ch = 7'h27;
      8'd41: ch = 7'h60;
      8'd43: ch = 7'h5C;
      8'd44: ch = 7'h5A;
      8'd45: ch = 7'h58;
      8'd46: ch = 7'h43;
      8'd47: ch = 7'h56;
      8'd48: ch = 7'h42;
      8'd49: ch = 7'h4E;
      8'd50: ch = 7'h4D;
      8'd51: ch = 7'h2C;
      8'd52: ch = 7'h2E;
      8'd53: ch = 7'h2F;
      8'd55: ch = 7'h2A;
      8'd57: ch = 7'h20;
      8'd74: ch = 7'h2D;
      8'd78: ch = 7'h2B;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  // Shifted key table (letters read as lower case)
  function automatic logic [6:0] shifted_key(input logic [7:0] code);
    logic [6:0] ch;
    ch = 7'h00;
    case (code)
      8'd2:  ch = 7'h21;
      8'd3:  ch = 7'h40;
      8'd4:  ch = 7'h23;
      8'd5:  ch = 7'h24;
      8'd6:  ch = 7'h25;
      8'd7:  ch = 7'h5E;
      8'd8:  ch = 7'h26;
      8'd9:  ch = 7'h2A;
      8'd10: ch = 7'h28;
      8'd11: ch = 7'h29;
      8'd12: ch = 7'h5F;
      8'd13: ch = 7'h2B;
      8'd16: ch = 7'h71;
      8'd17: ch = 7'h77;
      8'd18: ch = 7'h65;
      8'd19: ch = 7'h72;
      8'd20: ch = 7'h74;
      8'd21: ch = 7'h79;
      8'd22: ch = 7'h75;
      8'd23: ch = 7'h69;
      8'd24: ch = 7'h6F;
      8'd25: ch = 7'h70;
      8'd26: ch = 7'h7B;
      8'd27: ch = 7'h7D;
      8'd30: ch = 7'h61;
      8'd31: ch = 7'h73;
      8'd32: ch = 7'h64;
      8'd33: ch = 7'h66;
      8'd34: ch = 7'h67;
      8'd35: ch = 7'h68;
      8'd36: ch = 7'h6A;
      8'd37: ch = 7'h6B;
      8'd38: ch = 7'h6C;
      8'd39: ch = 7'h3A;
      8'd40: ch = 7'h22;
      8'd41: ch = 7'h7E;
      8'd43: ch = 7'h7C;
      8'd44: ch = 7'h7A;
      8'd45: ch = 7'h78;
      8'd46: ch = 7'h63;
      8'd47: ch = 7'h76;
      8'd48: ch = 7'h62;
      8'd49: ch = 7'h6E;
      8'd50: ch = 7'h6D;
      8'd51: ch = 7'h3C;
      8'd52: ch = 7'h3E;
      8'd53: ch = 7'h3F;
      default: ch = plain_key(code);
    endcase
    return ch;
  endfunction

endpackage

// File: design/sle_decode.sv
// Scan code decoder: key lookup and line edit decision for one beat.
module sle_decode (
  input  logic [7:0]         code,
  input  logic               shift_held,
  input  logic [7:0]         line_length,
  input  logic               echo_enable,
  input  logic [8:0]         line_capacity,
  output sle_pkg::sle_edit_t edit
);
  import sle_pkg::*;

  logic [6:0] plain_ch;
  logic [6:0] shift_ch;
  logic [8:0] cap_eff;
  logic [8:0] length_inc;
  logic       room;

  assign plain_ch   = plain_key(code);
  assign shift_ch   = shifted_key(code);
  assign cap_eff    = (line_capacity > 9'(CapLimit)) ? 9'(CapLimit) : line_capacity;
  assign length_inc = {1'b0, line_length} + 9'd1;
  // Room for one more character, keeping the terminator slot
  assign room       = (cap_eff != 9'd0) && (length_inc < cap_eff);

  always_comb begin
    edit             = '0;
    edit.shift_next  = shift_held;
    edit.length_next = line_length;
    if (code inside {CodeShiftLeft, CodeShiftRight}) begin
      edit.shift_next = 1'b1;
    end else if (code inside {CodeShiftLeftRel, CodeShiftRightRel}) begin
      edit.shift_next = 1'b0;
    end else if (code == CodeEnter) begin
      edit.has_result  = 1'b1;
      edit.kind        = KindLine;
      edit.position    = line_length;
      edit.length_next = 8'd0;
    end else if (code == CodeBackspace) begin
      // Erase only when there is something to erase
      if (line_length != 8'd0) begin
        edit.has_result  = 1'b1;
        edit.kind        = KindErase;
        edit.position    = line_length - 8'd1;
        edit.echo        = echo_enable;
        edit.length_next = line_length - 8'd1;
      end
    end else if ((plain_ch != 7'h00) && room) begin
      edit.has_result  = 1'b1;
      edit.kind        = KindAppend;
      edit.char_code   = shift_held ? shift_ch : plain_ch;
      edit.position    = line_length;
      edit.echo        = echo_enable;
      edit.length_next = length_inc[7:0];
    end
  end

endmodule

// File: design/scancode_line_editor_unit.sv
// Top level of the scancode line editor: input register, edit state, result register.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  input    | in        | in_valid/in_stall  | scancode
//  result   | out       | out_valid/out_stall| kind, char_code, position, echo
//  config   | in        | cfg_write          | cfg_index, cfg_data
//
//  One beat a cycle while in_stall is low. A scan code is registered in the input
//  register, decoded there and then registered in the result register once that
//  slot is free. rst clears the edit state and both valid flags, and sets echo on
//  and the line capacity to 256. A stalled result only holds up an input beat that
//  itself gives a result; shift and dropped codes still pass through.
module scancode_line_editor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [6:0] char_code,
  output logic [7:0] position,
  output logic       echo,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);
  import sle_pkg::*;

  logic       echo_enable;
  logic [8:0] line_capacity;
  logic       shift_held;
  logic [7:0] line_length;
  logic       s1_valid;
  logic [7:0] s1_code;
  logic       s1_go;
  sle_edit_t  edit;

  sle_decode u_decode (
    .code          (s1_code),
    .shift_held    (shift_held),
    .line_length   (line_length),
    .echo_enable   (echo_enable),
    .line_capacity (line_capacity),
    .edit          (edit)
  );

  // Held beat moves on when it gives no result or the result slot frees up
  assign s1_go    = s1_valid && (!edit.has_result || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable   <= 1'b1;
      line_capacity <= 9'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        RegEchoEnable:   echo_enable   <= cfg_data[0];
        RegLineCapacity: line_capacity <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_code <= scancode;
    end
  end

  // Edit state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held  <= 1'b0;
      line_length <= 8'd0;
    end else if (s1_go) begin
      shift_held  <= edit.shift_next;
      line_length <= edit.length_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && edit.has_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && edit.has_result) begin
      kind      <= edit.kind;
      char_code <= edit.char_code;
      position  <= edit.position;
      echo      <= edit.echo;
    end
  end

endmodule

// File: design/sle_checker.sv
// Port checker for the scancode line editor, bound to the top level.
`include "scancode_line_editor_unit_macros.svh"

module sle_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] kind,
  input logic [6:0] char_code,
  input logic [7:0] position,
  input logic       echo
);
  import sle_pkg::*;

  `SLE_ASSERT_ALWAYS(a_idle_after_reset, clk, $past(rst) |-> !out_valid, "result valid after reset")
  `SLE_ASSERT_CLK(a_valid_holds, clk, rst, out_valid && out_stall |=> out_valid, "stalled result dropped")
  `SLE_ASSERT_CLK(a_payload_holds, clk, rst, out_valid && out_stall |=> $stable({kind, char_code, position, echo}), "stalled result changed")
  `SLE_ASSERT_CLK(a_line_end_clean, clk, rst, out_valid && (kind == KindLine) |-> (char_code == 7'h00) && !echo, "line end carries a character or echo")
  `SLE_ASSERT_CLK(a_append_char, clk, rst, out_valid && (kind == KindAppend) |-> (char_code != 7'h00), "append without a character")

endmodule

bind scancode_line_editor_unit sle_port_checker u_sle_checker (.*);
